// ===== src/git_pkg.sv =====
// ----------------------------------------------------------------------------
// git_pkg: shared types, constants and fixed-point helpers
// Register codes, pixel format and mode codes, the configuration bundle and
// the constant-divide helpers used to widen, weigh and repack channels.
// ----------------------------------------------------------------------------
package git_pkg;

  localparam int PIX_W      = 24;
  localparam int GRAY_W     = 8;
  localparam int GAIN_W     = 16;
  localparam int OFFSET_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int SUM_W      = 18;

  // luma weights in thousandths
  localparam int W_R = 299;
  localparam int W_G = 587;
  localparam int W_B = 114;

  // reciprocals for exact floor division of bounded values
  localparam int RECIP_31   = 541201;  // ceil(2^24 / 31)
  localparam int RECIP_63   = 266306;  // ceil(2^24 / 63)
  localparam int RECIP_255  = 65794;   // ceil(2^24 / 255)
  localparam int RECIP_1000 = 67109;   // ceil(2^26 / 1000)

  localparam logic signed [GAIN_W-1:0]   GAIN_RESET   = 16'sd256;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 17'sd0;

  typedef enum logic [1:0] {
    MODE_LINEAR = 2'd0,
    MODE_LOG    = 2'd1,
    MODE_EXP    = 2'd2,
    MODE_PASS   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FMT_RGB888 = 2'd0,
    FMT_RGB565 = 2'd1,
    FMT_RGB555 = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_FORMAT = 2'd1,
    REG_GAIN   = 2'd2,
    REG_OFFSET = 2'd3
  } reg_e;

  typedef struct packed {
    mode_e                       mode;
    fmt_e                        fmt;
    logic signed [GAIN_W-1:0]    gain;
    logic signed [OFFSET_W-1:0]  offset;
  } cfg_t;

  // floor(c * 255 / 31)
  function automatic logic [7:0] widen5(input logic [4:0] c);
    logic [12:0] x;
    logic [32:0] p;
    x = 13'(c) * 13'd255;
    p = 33'(x) * 33'(RECIP_31);
    return p[31:24];
  endfunction

  // floor(c * 255 / 63)
  function automatic logic [7:0] widen6(input logic [5:0] c);
    logic [13:0] x;
    logic [32:0] p;
    x = 14'(c) * 14'd255;
    p = 33'(x) * 33'(RECIP_63);
    return p[31:24];
  endfunction

  // floor(s / 1000) for s up to 255000
  function automatic logic [7:0] gray_of_sum(input logic [SUM_W-1:0] s);
    logic [34:0] p;
    p = 35'(s) * 35'(RECIP_1000);
    return p[33:26];
  endfunction

  // floor(n * 31 / 255)
  function automatic logic [4:0] scale5(input logic [7:0] n);
    logic [13:0] x;
    logic [30:0] p;
    x = 14'(n) * 14'd31;
    p = 31'(x) * 31'(RECIP_255);
    return p[28:24];
  endfunction

  // floor(n * 63 / 255)
  function automatic logic [5:0] scale6(input logic [7:0] n);
    logic [13:0] x;
    logic [30:0] p;
    x = 14'(n) * 14'd63;
    p = 31'(x) * 31'(RECIP_255);
    return p[29:24];
  endfunction

endpackage

// ===== src/gray_intensity_transform.sv =====
// ----------------------------------------------------------------------------
// gray_intensity_transform: grayscale and intensity mapping of a pixel stream
// Takes one pixel beat per clock and returns one result beat per clock when
// the output is not stalled; the depth is set by the seven register stages
// (capture, luma sum, divide, operand select with table lookup, gain
// multiply, offset and saturate, repack). Every stage holds its own valid bit,
// so empty stages keep filling while the output beat waits under stall. Log
// and exp terms come from constant tables built at elaboration. Registers
// (mode, pixel format, gain, offset) are written through the plain write port
// and must only change while no beat is in flight.
// ----------------------------------------------------------------------------
module gray_intensity_transform #(
  parameter int TABLE_FRAC_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [git_pkg::PIX_W-1:0]       pixel_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [git_pkg::PIX_W-1:0]       pixel_out_o,
  output logic [git_pkg::GRAY_W-1:0]      gray_out_o,
  input  logic                            cfg_we_i,
  input  logic [git_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [git_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import git_pkg::*;

  mode_e                      mode_q;
  fmt_e                       fmt_q;
  logic signed [GAIN_W-1:0]   gain_q;
  logic signed [OFFSET_W-1:0] offset_q;
  cfg_t                       cfg;

  logic              gray_ready, gray_valid;
  logic [PIX_W-1:0]  gray_pix;
  logic [GRAY_W-1:0] gray_lvl;
  logic              map_ready, map_valid;
  logic [PIX_W-1:0]  map_pix;
  logic [GRAY_W-1:0] map_gray, map_level;
  logic              pack_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_LINEAR;
      fmt_q    <= FMT_RGB888;
      gain_q   <= GAIN_RESET;
      offset_q <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_MODE:   mode_q   <= mode_e'(cfg_wdata_i[1:0]);
        REG_FORMAT: fmt_q    <= fmt_e'(cfg_wdata_i[1:0]);
        REG_GAIN:   gain_q   <= $signed(cfg_wdata_i[GAIN_W-1:0]);
        REG_OFFSET: offset_q <= $signed(cfg_wdata_i[OFFSET_W-1:0]);
        default:    ;
      endcase
    end
  end

  assign cfg.mode   = mode_q;
  assign cfg.fmt    = fmt_q;
  assign cfg.gain   = gain_q;
  assign cfg.offset = offset_q;

  git_gray u_gray (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (gray_ready),
    .pixel_i     (pixel_in_i),
    .out_valid_o (gray_valid),
    .out_ready_i (map_ready),
    .pix_o       (gray_pix),
    .gray_o      (gray_lvl)
  );

  git_map #(
    .TABLE_FRAC_BITS(TABLE_FRAC_BITS)
  ) u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (gray_valid),
    .in_ready_o  (map_ready),
    .pix_i       (gray_pix),
    .gray_i      (gray_lvl),
    .out_valid_o (map_valid),
    .out_ready_i (pack_ready),
    .pix_o       (map_pix),
    .gray_o      (map_gray),
    .level_o     (map_level)
  );

  git_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (map_valid),
    .in_ready_o  (pack_ready),
    .pix_i       (map_pix),
    .gray_i      (map_gray),
    .level_i     (map_level),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .pixel_o     (pixel_out_o),
    .gray_o      (gray_out_o)
  );

  assign in_stall_o = !gray_ready;

endmodule

// ===== src/git_gray.sv =====
// ----------------------------------------------------------------------------
// git_gray: unpack and gray level
// Three stages: input capture with format masking, channel widening and the
// weighted luma sum, then the divide by 1000 down to an 8-bit gray level.
// ----------------------------------------------------------------------------
module git_gray (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  git_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [git_pkg::PIX_W-1:0]   pixel_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [git_pkg::PIX_W-1:0]   pix_o,
  output logic [git_pkg::GRAY_W-1:0]  gray_o
);
  import git_pkg::*;

  logic              a_v_q, b_v_q, c_v_q;
  logic              a_en, b_en, c_en;
  logic [PIX_W-1:0]  pix_masked;
  logic [PIX_W-1:0]  a_pix_q, b_pix_q, c_pix_q;
  logic [7:0]        ch_r, ch_g, ch_b;
  logic [SUM_W-1:0]  sum_d, b_sum_q;
  logic [GRAY_W-1:0] c_gray_q;

  assign c_en       = !c_v_q || out_ready_i;
  assign b_en       = !b_v_q || c_en;
  assign a_en       = !a_v_q || b_en;
  assign in_ready_o = a_en;

  // bits above a 16-bit format's width are dropped here
  always_comb begin
    case (cfg_i.fmt)
      FMT_RGB565: pix_masked = {8'd0, pixel_i[15:0]};
      FMT_RGB555: pix_masked = {9'd0, pixel_i[14:0]};
      default:    pix_masked = pixel_i;
    endcase
  end

  always_comb begin
    case (cfg_i.fmt)
      FMT_RGB565: begin
        ch_r = widen5(a_pix_q[15:11]);
        ch_g = widen6(a_pix_q[10:5]);
        ch_b = widen5(a_pix_q[4:0]);
      end
      FMT_RGB555: begin
        ch_r = widen5(a_pix_q[14:10]);
        ch_g = widen5(a_pix_q[9:5]);
        ch_b = widen5(a_pix_q[4:0]);
      end
      default: begin
        ch_r = a_pix_q[23:16];
        ch_g = a_pix_q[15:8];
        ch_b = a_pix_q[7:0];
      end
    endcase
    sum_d = SUM_W'(ch_r) * SUM_W'(W_R) + SUM_W'(ch_g) * SUM_W'(W_G)
          + SUM_W'(ch_b) * SUM_W'(W_B);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_en) a_v_q <= in_valid_i;
      if (b_en) b_v_q <= a_v_q;
      if (c_en) c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en && in_valid_i) begin
      a_pix_q <= pix_masked;
    end
    if (b_en && a_v_q) begin
      b_pix_q <= a_pix_q;
      b_sum_q <= sum_d;
    end
    if (c_en && b_v_q) begin
      c_pix_q  <= b_pix_q;
      c_gray_q <= gray_of_sum(b_sum_q);
    end
  end

  assign out_valid_o = c_v_q;
  assign pix_o       = c_pix_q;
  assign gray_o      = c_gray_q;

endmodule

// ===== src/git_rom.sv =====
// ----------------------------------------------------------------------------
// git_rom: log and exp lookup tables
// 256-entry constant tables of ln(1+g) and exp(g/255) with TABLE_FRAC_BITS
// fraction bits, built at elaboration from 30-bit fraction integer series.
// ----------------------------------------------------------------------------
module git_rom #(
  parameter int TABLE_FRAC_BITS = 12
) (
  input  logic [7:0]                   idx_i,
  input  logic                         sel_exp_i,
  output logic [TABLE_FRAC_BITS+2:0]   value_o
);

  localparam int TW    = TABLE_FRAC_BITS + 3;
  localparam int WFRAC = 30;
  localparam int SH    = WFRAC - TABLE_FRAC_BITS;
  localparam logic [63:0] LN2_W = 64'h2C5C85FE;

  // shift-subtract divide, only evaluated while building the tables
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] ln_wide(input logic [31:0] x);
    logic [63:0] one;
    logic [63:0] m;
    logic [63:0] z;
    logic [63:0] zz;
    logic [63:0] term;
    logic [63:0] sum;
    logic [5:0]  k;
    one = 64'd1 << WFRAC;
    k   = '0;
    sum = '0;
    for (int j = 0; j < 31; j++) begin
      if ((x >> (j + 1)) != 32'd0) k = 6'(j + 1);
    end
    m    = (64'(x) << WFRAC) >> k;
    z    = udiv64((m - one) << WFRAC, m + one);
    zz   = (z * z) >> WFRAC;
    term = z;
    for (int n = 0; n < 24; n++) begin
      sum  = sum + udiv64(term, 64'(2 * n + 1));
      term = (term * zz) >> WFRAC;
    end
    return (sum << 1) + 64'(k) * LN2_W;
  endfunction

  function automatic logic [63:0] exp_wide(input logic [31:0] g);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y    = udiv64(64'(g) << WFRAC, 64'd255);
    term = 64'd1 << WFRAC;
    sum  = term;
    for (int n = 1; n < 25; n++) begin
      term = udiv64((term * y) >> WFRAC, 64'(n));
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] rom_round(input logic [63:0] v);
    return (v + (64'd1 << (SH - 1))) >> SH;
  endfunction

  logic [TW-1:0] log_tab [256];
  logic [TW-1:0] exp_tab [256];

  for (genvar gi = 0; gi < 256; gi++) begin : g_entry
    localparam logic [63:0] LOG_V = rom_round(ln_wide(32'(gi + 1)));
    localparam logic [63:0] EXP_V = rom_round(exp_wide(32'(gi)));
    assign log_tab[gi] = LOG_V[TW-1:0];
    assign exp_tab[gi] = EXP_V[TW-1:0];
  end

  assign value_o = sel_exp_i ? exp_tab[idx_i] : log_tab[idx_i];

endmodule

// ===== src/git_map.sv =====
// ----------------------------------------------------------------------------
// git_map: intensity mapping
// Three stages: operand select (scaled gray or table term), gain multiply,
// then offset add, truncation and saturation to 0..255.
// ----------------------------------------------------------------------------
module git_map #(
  parameter int TABLE_FRAC_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  git_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [git_pkg::PIX_W-1:0]   pix_i,
  input  logic [git_pkg::GRAY_W-1:0]  gray_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [git_pkg::PIX_W-1:0]   pix_o,
  output logic [git_pkg::GRAY_W-1:0]  gray_o,
  output logic [git_pkg::GRAY_W-1:0]  level_o
);
  import git_pkg::*;

  localparam int F  = TABLE_FRAC_BITS;
  localparam int TW = F + 3;           // table term width
  localparam int OW = F + 8;           // operand width
  localparam int PW = GAIN_W + OW + 1; // signed product width
  localparam int AW = F + 26;          // accumulator width

  logic                 d_v_q, e_v_q, f_v_q;
  logic                 d_en, e_en, f_en;
  logic [TW-1:0]        rom_val;
  logic [OW-1:0]        op_d, d_op_q;
  logic signed [PW-1:0] prod_d, e_prod_q;
  logic signed [AW-1:0] acc;
  logic [GRAY_W-1:0]    lvl_d, f_lvl_q;
  logic [PIX_W-1:0]     d_pix_q, e_pix_q, f_pix_q;
  logic [GRAY_W-1:0]    d_gray_q, e_gray_q, f_gray_q;

  assign f_en       = !f_v_q || out_ready_i;
  assign e_en       = !e_v_q || f_en;
  assign d_en       = !d_v_q || e_en;
  assign in_ready_o = d_en;

  git_rom #(
    .TABLE_FRAC_BITS(TABLE_FRAC_BITS)
  ) u_rom (
    .idx_i     (gray_i),
    .sel_exp_i (cfg_i.mode == MODE_EXP),
    .value_o   (rom_val)
  );

  // linear gray is lifted by F so every mode ends with 8+F fraction bits
  always_comb begin
    case (cfg_i.mode)
      MODE_LOG, MODE_EXP: op_d = OW'(rom_val);
      default:            op_d = OW'(gray_i) << F;
    endcase
  end

  assign prod_d = PW'(cfg_i.gain) * PW'($signed({1'b0, d_op_q}));

  always_comb begin
    acc = AW'(e_prod_q) + (AW'(cfg_i.offset) <<< F);
    if (acc[AW-1]) begin
      lvl_d = '0;
    end else if (|acc[AW-2:16+F]) begin
      lvl_d = '1;
    end else begin
      lvl_d = acc[8+F +: GRAY_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else begin
      if (d_en) d_v_q <= in_valid_i;
      if (e_en) e_v_q <= d_v_q;
      if (f_en) f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_en && in_valid_i) begin
      d_op_q   <= op_d;
      d_pix_q  <= pix_i;
      d_gray_q <= gray_i;
    end
    if (e_en && d_v_q) begin
      e_prod_q <= prod_d;
      e_pix_q  <= d_pix_q;
      e_gray_q <= d_gray_q;
    end
    if (f_en && e_v_q) begin
      f_lvl_q  <= lvl_d;
      f_pix_q  <= e_pix_q;
      f_gray_q <= e_gray_q;
    end
  end

  assign out_valid_o = f_v_q;
  assign pix_o       = f_pix_q;
  assign gray_o      = f_gray_q;
  assign level_o     = f_lvl_q;

endmodule

// ===== src/git_pack.sv =====
// ----------------------------------------------------------------------------
// git_pack: repack and output register
// Spreads the mapped level into every channel of the configured packing, or
// passes the pixel through untouched in pass mode, into the output register.
// ----------------------------------------------------------------------------
module git_pack (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  git_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [git_pkg::PIX_W-1:0]   pix_i,
  input  logic [git_pkg::GRAY_W-1:0]  gray_i,
  input  logic [git_pkg::GRAY_W-1:0]  level_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [git_pkg::PIX_W-1:0]   pixel_o,
  output logic [git_pkg::GRAY_W-1:0]  gray_o
);
  import git_pkg::*;

  logic              v_q;
  logic              en;
  logic [4:0]        c5;
  logic [5:0]        c6;
  logic [PIX_W-1:0]  pixel_d, pixel_q;
  logic [GRAY_W-1:0] gray_d, gray_q;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  assign c5 = scale5(level_i);
  assign c6 = scale6(level_i);

  always_comb begin
    if (cfg_i.mode == MODE_PASS) begin
      pixel_d = pix_i;
      gray_d  = gray_i;
    end else begin
      gray_d = level_i;
      case (cfg_i.fmt)
        FMT_RGB565: pixel_d = {8'd0, c5, c6, c5};
        FMT_RGB555: pixel_d = {9'd0, c5, c5, c5};
        default:    pixel_d = {level_i, level_i, level_i};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      pixel_q <= pixel_d;
      gray_q  <= gray_d;
    end
  end

  assign out_valid_o = v_q;
  assign pixel_o     = pixel_q;
  assign gray_o      = gray_q;

endmodule
